@@ rtl/fgc_pkg.sv @@
// fgc_pkg: shared types, constants and register codes for the footswitch gesture classifier
// used by fgc_csr, fgc_update and footswitch_gesture_classifier; no dependencies

package fgc_pkg;

   localparam int NUM_SWITCHES_DEF = 8;

   localparam int SWITCH_W   = 3;
   localparam int HELD_W     = 16;
   localparam int US_W       = 24;
   localparam int MASK_W     = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [US_W-1:0]   TAP_WINDOW_RST     = 24'd500000;
   localparam logic [HELD_W-1:0] HOLD_THRESHOLD_RST = 16'd1000;
   localparam logic [MASK_W-1:0] SUPPRESS_MASK_RST  = 8'd0;

   typedef enum logic [1:0] {
      REG_TAP_WINDOW     = 2'd0,
      REG_HOLD_THRESHOLD = 2'd1,
      REG_SUPPRESS_MASK  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [SWITCH_W-1:0] switch_index;
      logic                pressed;
      logic                released;
      logic [HELD_W-1:0]   held_ms;
      logic [US_W-1:0]     elapsed_us;
   } req_data_type;

   typedef struct packed {
      logic [SWITCH_W-1:0] switch_out;
      logic                single_press;
      logic                double_tap;
      logic                release_event;
      logic                hold_event;
   } rsp_data_type;

   typedef struct packed {
      logic [US_W-1:0]   tap_window_us;
      logic [HELD_W-1:0] hold_threshold_ms;
      logic [MASK_W-1:0] suppress_mask;
   } cfg_type;

endpackage

@@ rtl/fgc_csr.sv @@
// fgc_csr: configuration registers behind an apb-style port
// depends on fgc_pkg

module fgc_csr
   import fgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TAP_WINDOW:     cfg_in.tap_window_us     = pwdata[US_W-1:0];
            REG_HOLD_THRESHOLD: cfg_in.hold_threshold_ms = pwdata[HELD_W-1:0];
            REG_SUPPRESS_MASK:  cfg_in.suppress_mask     = pwdata[MASK_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TAP_WINDOW:     prdata = {{(CSR_DATA_W-US_W){1'b0}}, cfg_ff.tap_window_us};
         REG_HOLD_THRESHOLD: prdata = {{(CSR_DATA_W-HELD_W){1'b0}}, cfg_ff.hold_threshold_ms};
         REG_SUPPRESS_MASK:  prdata = {{(CSR_DATA_W-MASK_W){1'b0}}, cfg_ff.suppress_mask};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_window_us     <= TAP_WINDOW_RST;
         cfg_ff.hold_threshold_ms <= HOLD_THRESHOLD_RST;
         cfg_ff.suppress_mask     <= SUPPRESS_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/fgc_update.sv @@
// fgc_update: per-switch state (tap window, countdown, hold guard) and the combinational classifier
// depends on fgc_pkg

module fgc_update
   import fgc_pkg::*;
#(
   parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         upd_en,
   input  req_data_type item,
   input  cfg_type      cfg,
   output rsp_data_type result
);

   localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

   logic            armed_ff  [NUM_SWITCHES];
   logic            armed_in  [NUM_SWITCHES];
   logic [US_W-1:0] window_ff [NUM_SWITCHES];
   logic [US_W-1:0] window_in [NUM_SWITCHES];
   logic            fired_ff  [NUM_SWITCHES];
   logic            fired_in  [NUM_SWITCHES];

   logic [5:0]       sw_ext;
   logic [IDX_W-1:0] idx;
   logic             in_range;
   logic             cur_armed;
   logic [US_W-1:0]  cur_window;
   logic             cur_fired;
   logic             masked;
   logic             dbl;
   logic             single;
   logic             hold;
   logic [US_W-1:0]  counted;

   assign sw_ext   = {3'b000, item.switch_index};
   assign idx      = sw_ext[IDX_W-1:0];
   assign in_range = sw_ext < 6'(NUM_SWITCHES);

   assign cur_armed  = armed_ff[idx];
   assign cur_window = window_ff[idx];
   assign cur_fired  = fired_ff[idx];

   assign masked  = cfg.suppress_mask[item.switch_index];
   assign dbl     = in_range && item.pressed && cur_armed && (cur_window != '0);
   assign single  = in_range && item.pressed && !(dbl && masked);
   assign hold    = in_range && (item.held_ms >= cfg.hold_threshold_ms) && !cur_fired;
   // saturating countdown
   assign counted = (cur_window > item.elapsed_us) ? cur_window - item.elapsed_us : '0;

   always_comb begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
         armed_in[i]  = armed_ff[i];
         window_in[i] = window_ff[i];
         fired_in[i]  = fired_ff[i];
      end
      if (upd_en && in_range) begin
         if (hold) begin
            fired_in[idx] = 1'b1;
         end
         if (item.released) begin
            fired_in[idx] = 1'b0;
         end
         if (cur_armed) begin
            window_in[idx] = counted;
            armed_in[idx]  = (counted != '0);
         end
         if (item.pressed) begin
            if (dbl) begin
               armed_in[idx]  = 1'b0;
               window_in[idx] = '0;
            end else begin
               armed_in[idx]  = 1'b1;
               window_in[idx] = cfg.tap_window_us;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            armed_ff[i]  <= 1'b0;
            window_ff[i] <= '0;
            fired_ff[i]  <= 1'b0;
         end
      end else begin
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            armed_ff[i]  <= armed_in[i];
            window_ff[i] <= window_in[i];
            fired_ff[i]  <= fired_in[i];
         end
      end
   end

   always_comb begin
      result.switch_out    = item.switch_index;
      result.single_press  = single;
      result.double_tap    = dbl;
      result.release_event = item.released;
      result.hold_event    = hold;
   end

   // a double tap closes the window of its switch
   a_dbl_disarms: assert property (@(posedge clock) disable iff (reset)
      upd_en && dbl |=> !armed_ff[$past(idx)])
      else $error("double tap left switch armed");

   // a fired hold without a release sets the guard
   a_hold_guard: assert property (@(posedge clock) disable iff (reset)
      upd_en && hold && !item.released |=> fired_ff[$past(idx)])
      else $error("hold guard not set");

   // a double tap on an unmasked switch still reports the press
   a_unmasked_single: assert property (@(posedge clock) disable iff (reset)
      upd_en && dbl && !masked |-> single)
      else $error("single press lost on unmasked switch");

   // switches beyond the configured count raise no press or hold events
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      upd_en && !in_range |-> !single && !dbl && !hold)
      else $error("event on out-of-range switch");

endmodule

@@ rtl/footswitch_gesture_classifier.sv @@
// footswitch_gesture_classifier: top level, input register, result register and csr port
// depends on fgc_pkg, fgc_csr, fgc_update
//
// channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------------
// req      | req_valid / req_stall       | req_data  (switch, edges, held, elapsed)
// rsp      | rsp_valid / rsp_stall       | rsp_data  (switch, press/tap/release/hold)
// csr      | psel/penable/pwrite, pready | paddr, pwdata, prdata (3 registers)
//
// one transaction per cycle sustained while rsp_stall is low; a poll passes through the
// input register, then the result register, before it shows up on rsp
// the per-switch read-modify-write sits between the input and result registers, so
// back-to-back polls of the same switch always see the updated state
// synchronous reset clears switch state and loads the register defaults
// a stalled result holds; the input register keeps taking polls until it is full too

module footswitch_gesture_classifier
   import fgc_pkg::*;
#(
   parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // poll input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   // event output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   rsp_data_type upd_result;

   // input register
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_data_type s1_data_ff;
   req_data_type s1_data_in;

   // result register
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type out_data_in;

   logic out_free;
   logic s1_adv;
   logic accept;

   // result slot is free when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_data_in  = upd_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   fgc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // state commits on the same edge that the result is registered
   fgc_update #(
      .NUM_SWITCHES (NUM_SWITCHES)
   ) u_update (
      .clock  (clock),
      .reset  (reset),
      .upd_en (s1_adv),
      .item   (s1_data_ff),
      .cfg    (cfg),
      .result (upd_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
